// ----- rtl/hsfd_pkg.sv -----
package hsfd_pkg;

  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

  // Place of a byte within the six-byte measurement frame
  typedef enum logic [2:0] {
    POS_T_HI,
    POS_T_LO,
    POS_T_CRC,
    POS_H_HI,
    POS_H_LO,
    POS_H_CRC
  } pos_t;

  // Raw frame handed from the byte accumulator to the scaling pipe
  typedef struct packed {
    logic        ok;
    logic [15:0] t_raw;
    logic [15:0] h_raw;
  } frame_t;

  // CRC-8, MSB first, one whole byte per call
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/hsfd_frame_acc.sv -----
module hsfd_frame_acc (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                frm_valid,
  input  logic                frm_ready,
  output hsfd_pkg::frame_t    frm
);

  hsfd_pkg::pos_t pos, pos_next, pos_eff;
  logic [7:0]  crc, crc_next, crc_base, crc_fed;
  logic [15:0] t_word, t_word_next;
  logic [7:0]  h_hi, h_hi_next, h_lo, h_lo_next;
  logic        t_ok, t_ok_next;
  logic        emit;
  logic        accept;

  assign in_ready = !frm_valid || frm_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos_eff     = frame_start ? hsfd_pkg::POS_T_HI : pos;
    crc_base    = (pos_eff == hsfd_pkg::POS_T_HI) ? hsfd_pkg::CRC_INIT : crc;
    crc_fed     = hsfd_pkg::crc_feed(crc_base, data_byte);
    pos_next    = pos;
    crc_next    = crc;
    t_word_next = t_word;
    h_hi_next   = h_hi;
    h_lo_next   = h_lo;
    t_ok_next   = t_ok;
    emit        = 1'b0;
    case (pos_eff)
      hsfd_pkg::POS_T_HI: begin
        t_word_next = {data_byte, t_word[7:0]};
        crc_next    = crc_fed;
        pos_next    = hsfd_pkg::POS_T_LO;
      end
      hsfd_pkg::POS_T_LO: begin
        t_word_next = {t_word[15:8], data_byte};
        crc_next    = crc_fed;
        pos_next    = hsfd_pkg::POS_T_CRC;
      end
      hsfd_pkg::POS_T_CRC: begin
        t_ok_next = (crc_base == data_byte);
        crc_next  = hsfd_pkg::CRC_INIT;
        pos_next  = hsfd_pkg::POS_H_HI;
      end
      hsfd_pkg::POS_H_HI: begin
        h_hi_next = data_byte;
        crc_next  = crc_fed;
        pos_next  = hsfd_pkg::POS_H_LO;
      end
      hsfd_pkg::POS_H_LO: begin
        h_lo_next = data_byte;
        crc_next  = crc_fed;
        pos_next  = hsfd_pkg::POS_H_CRC;
      end
      hsfd_pkg::POS_H_CRC: begin
        crc_next = hsfd_pkg::CRC_INIT;
        pos_next = hsfd_pkg::POS_T_HI;
        emit     = 1'b1;
      end
      default: begin
        // unreachable position: restart the frame
        crc_next = hsfd_pkg::CRC_INIT;
        pos_next = hsfd_pkg::POS_T_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= hsfd_pkg::POS_T_HI;
      crc    <= hsfd_pkg::CRC_INIT;
      t_word <= '0;
      h_hi   <= '0;
      h_lo   <= '0;
      t_ok   <= 1'b0;
    end else if (accept) begin
      pos    <= pos_next;
      crc    <= crc_next;
      t_word <= t_word_next;
      h_hi   <= h_hi_next;
      h_lo   <= h_lo_next;
      t_ok   <= t_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (in_ready) begin
      frm_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frm.ok    <= t_ok && (crc_base == data_byte);
      frm.t_raw <= t_word;
      frm.h_raw <= {h_hi, h_lo};
    end
  end

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> crc == hsfd_pkg::CRC_INIT && pos == hsfd_pkg::POS_T_HI)
    else $error("CRC or position not restarted after last byte of frame");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> pos == hsfd_pkg::POS_T_LO)
    else $error("start flag did not restart the byte count");

  a_frame_kept: assert property (@(posedge clk) disable iff (rst)
    frm_valid && !frm_ready |=> frm_valid && $stable(frm))
    else $error("pending frame lost while stalled");

endmodule

// ----- rtl/hsfd_scale.sv -----
module hsfd_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                frm_valid,
  output logic                frm_ready,
  input  hsfd_pkg::frame_t    frm,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic signed [14:0]  out_temp,
  output logic [13:0]         out_hum
);

  logic        p_v, p_ok;
  logic [30:0] p_t;
  logic [29:0] p_h;
  logic        out_adv;
  logic [14:0] q0_t, ts, temp;
  logic [13:0] q0_h, hs;
  logic [16:0] r_t, r_h;

  assign out_adv   = !out_valid || out_ready;
  assign frm_ready = !p_v || out_adv;

  // Stage one: scale by the constant span
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (frm_ready) begin
      p_v <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      p_ok <= frm.ok;
      p_t  <= 31'(frm.t_raw) * 31'(hsfd_pkg::TEMP_SCALE);
      p_h  <= 30'(frm.h_raw) * 30'(hsfd_pkg::HUM_SCALE);
    end
  end

  // Divide by 2^16-1: x = q0*(2^16-1) + (q0 + low half), one correction step
  always_comb begin
    q0_t = p_t[30:16];
    r_t  = 17'(p_t[15:0]) + 17'(q0_t);
    ts   = q0_t + 15'(r_t >= 17'(hsfd_pkg::FULL_SCALE));
    temp = ts - hsfd_pkg::TEMP_OFFSET;
    q0_h = p_h[29:16];
    r_h  = 17'(p_h[15:0]) + 17'(q0_h);
    hs   = q0_h + 14'(r_h >= 17'(hsfd_pkg::FULL_SCALE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p_v) begin
      out_ok   <= p_ok;
      out_temp <= p_ok ? $signed(temp) : '0;
      out_hum  <= p_ok ? hs : '0;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_temp == 15'sd0 && out_hum == 14'd0)
    else $error("invalid frame carries non-zero readings");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_hum <= 14'd10000 && out_temp >= -15'sd4500 && out_temp <= 15'sd13000)
    else $error("scaled reading out of range");

  a_prod_kept: assert property (@(posedge clk) disable iff (rst)
    p_v && !out_adv |=> p_v && $stable(p_t) && $stable(p_h))
    else $error("product stage dropped while output stalled");

endmodule

// ----- rtl/humidity_sensor_frame_decoder.sv -----
// Decodes six-byte temperature/humidity sensor frames, one byte per beat on the
// slave side (temperature high, low, CRC, humidity high, low, CRC; tuser marks the
// first byte and restarts the count). A byte is taken every cycle while the frame
// register is free or being drained; the CRC-8 is updated a whole byte per cycle.
// The sixth byte yields one result beat through three registers: the frame
// register, the constant multiplier stage, and the divide-by-65535 correction and
// output register. Readings are zero when either CRC fails.
module humidity_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic        m_axis_tuser    // [0] frame_valid
);

  hsfd_pkg::frame_t   frm;
  logic               frm_valid;
  logic               frm_ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;

  hsfd_frame_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .data_byte   (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .frm_valid   (frm_valid),
    .frm_ready   (frm_ready),
    .frm         (frm)
  );

  hsfd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_ok    (m_axis_tuser),
    .out_temp  (temperature_centi),
    .out_hum   (humidity_centi)
  );

  assign m_axis_tdata = {3'b000, humidity_centi, temperature_centi};

endmodule
